>>> rtl/pca_pkg.sv
// Package for the per-column polynomial activation block.
// Holds the fixed-point constants, shared types and the Q4.12 product helper.
// No dependencies.
package pca_pkg;

  // Field widths of the channels
  localparam int unsigned ColW    = 10;
  localparam int unsigned CoefIdxW = 3;
  localparam int unsigned DataW   = 16;
  localparam int unsigned FracW   = 12;

  // Number of coefficients per column (c0..c4)
  localparam int unsigned NumCoef = 5;

  // Default column count
  localparam int unsigned DefColumns = 1024;

  // One column's coefficient set as read from the store
  typedef logic [NumCoef-1:0][DataW-1:0] coeff_set_t;

  // Rounded and saturated product
  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
  } qprod_t;

  // Q4.12 x Q4.12: exact product, round to nearest (ties up), saturate to 16 bits
  function automatic qprod_t qmul(input logic signed [DataW-1:0] a,
                                  input logic signed [DataW-1:0] b);
    logic signed [2*DataW:0]         p;
    logic signed [2*DataW-FracW:0]   q;
    qprod_t                          r;
    p = $signed(a) * $signed(b);
    p = p + $signed((2*DataW+1)'(1 << (FracW - 1)));
    q = (2*DataW-FracW+1)'(p >>> FracW);
    if (q > $signed((2*DataW-FracW+1)'(32767))) begin
      r.val = 16'sh7FFF;
      r.sat = 1'b1;
    end else if (q < -$signed((2*DataW-FracW+1)'(32768))) begin
      r.val = 16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.val = DataW'(q);
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/pca_if.sv
// Valid/ready channel interfaces of the per-column polynomial activation block.
// Depends on pca_pkg for field widths.

// Input items: coefficient writes and evaluate requests
interface pca_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic [pca_pkg::ColW-1:0]              column;
  logic [pca_pkg::CoefIdxW-1:0]          coeff_index;
  logic signed [pca_pkg::DataW-1:0]      value;

  modport source (output valid, func, column, coeff_index, value, input ready);
  modport sink   (input valid, func, column, coeff_index, value, output ready);
endinterface

// Result items
interface pca_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pca_pkg::DataW-1:0]      result;
  logic                                  saturated;

  modport source (output valid, result, saturated, input ready);
  modport sink   (input valid, result, saturated, output ready);
endinterface

// Configuration writes (degree_four_mode)
interface pca_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/pca_coeff_store.sv
// Coefficient store: one single-port-write, single-read memory per coefficient.
// Depends on pca_pkg for widths and the coefficient set type.
module pca_coeff_store #(
  parameter int unsigned COLUMNS = pca_pkg::DefColumns,
  parameter int unsigned AddrW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic                             wr_en_i,
  input  logic [pca_pkg::CoefIdxW-1:0]     wr_idx_i,
  input  logic [AddrW-1:0]                 addr_i,
  input  logic [pca_pkg::DataW-1:0]        wr_data_i,
  output pca_pkg::coeff_set_t              rd_data_o
);
  import pca_pkg::*;

  for (genvar g = 0; g < NumCoef; g++) begin : g_bank
    logic [DataW-1:0] mem [COLUMNS];
    logic [DataW-1:0] rd_q;

    // Write the selected coefficient bank
    always_ff @(posedge clk_i) begin
      if (en_i && wr_en_i && (wr_idx_i == CoefIdxW'(g))) begin
        mem[addr_i] <= wr_data_i;
      end
    end

    // Registered read, held while the pipeline stalls
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_q <= mem[addr_i];
      end
    end

    assign rd_data_o[g] = rd_q;
  end

endmodule

>>> rtl/per_column_poly_activation_top.sv
// Per-column polynomial activation: c0 + c1*v + c2*v^2 (+ c3*v^3 + c4*v^4) in Q4.12.
// The block takes one item every cycle while no stall holds the output. There are five
// pipeline registers, s1 to s4 and the output register, and the transfer edge loads the
// first one with the sample. The depth is set by the memory read, the three
// dependent multiply levels (v^2, then v^3/v^4, then c3*v^3/c4*v^4) and the final
// sum. All stages advance together whenever the output register is empty or being
// taken, so a stall at the output holds every stage. Write items use a pipeline slot
// and give no result. Coefficients live in five memories of COLUMNS entries each and
// must be written before a column is evaluated; no clearing pass is done after reset.
// Depends on pca_pkg, pca_if and pca_coeff_store.
module per_column_poly_activation_top #(
  parameter int unsigned COLUMNS = pca_pkg::DefColumns
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pca_cfg_if.sink   cfg_i,
  pca_in_if.sink    sample_i,
  pca_out_if.source result_o
);
  import pca_pkg::*;

  localparam int unsigned AddrW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned CmpW  = 18;
  localparam int unsigned S4W   = DataW + 2;
  localparam int unsigned S5W   = DataW + 3;

  // Pipeline advance: output register empty or being taken
  logic adv;
  assign adv = !result_o.valid || result_o.ready;
  assign sample_i.ready = adv;

  // Configuration register
  logic mode_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.data;
    end
  end

  // Input decode
  logic             in_xfer;
  logic             col_ok;
  logic [AddrW-1:0] addr;
  logic             wr_en;
  assign in_xfer = sample_i.valid && adv;
  assign col_ok  = CmpW'(sample_i.column) < CmpW'(COLUMNS);
  assign addr    = AddrW'(sample_i.column);
  assign wr_en   = sample_i.valid && !sample_i.func && col_ok &&
                   (sample_i.coeff_index < CoefIdxW'(NumCoef));

  coeff_set_t coef;

  pca_coeff_store #(
    .COLUMNS (COLUMNS),
    .AddrW   (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .en_i      (adv),
    .wr_en_i   (wr_en),
    .wr_idx_i  (sample_i.coeff_index),
    .addr_i    (addr),
    .wr_data_i (sample_i.value),
    .rd_data_o (coef)
  );

  // Stage valid bits
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_xfer && sample_i.func;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // Stage 1: sample and column check, coefficients read from the store
  logic                    s1_ok_q;
  logic signed [DataW-1:0] s1_v_q;

  // Stage 2: v^2 and c1*v
  qprod_t                  p_v2, p_t1;
  logic                    s2_ok_q, s2_sat_q;
  logic signed [DataW-1:0] s2_v_q, s2_v2_q, s2_t1_q, s2_c0_q, s2_c2_q, s2_c3_q, s2_c4_q;
  assign p_v2 = qmul(s1_v_q, s1_v_q);
  assign p_t1 = qmul($signed(coef[1]), s1_v_q);

  // Stage 3: c2*v^2, v^3, v^4
  qprod_t                  p_t2, p_v3, p_v4;
  logic                    s3_ok_q, s3_sat_q, s3_satx_q;
  logic signed [DataW-1:0] s3_c0_q, s3_t1_q, s3_t2_q, s3_v3_q, s3_v4_q, s3_c3_q, s3_c4_q;
  assign p_t2 = qmul(s2_c2_q, s2_v2_q);
  assign p_v3 = qmul(s2_v2_q, s2_v_q);
  assign p_v4 = qmul(s2_v2_q, s2_v2_q);

  // Stage 4: c3*v^3, c4*v^4 and the degree-two partial sum
  qprod_t                  p_t3, p_t4;
  logic                    s4_ok_q, s4_sat_q, s4_satx_q;
  logic signed [S4W-1:0]   s4_sum_q;
  logic signed [DataW-1:0] s4_t3_q, s4_t4_q;
  assign p_t3 = qmul(s3_c3_q, s3_v3_q);
  assign p_t4 = qmul(s3_c4_q, s3_v4_q);

  // Stage 5: final sum and saturation into the output register
  logic signed [S5W-1:0]   sum;
  logic signed [DataW-1:0] res_d, res_q;
  logic                    sat_d, sat_q;
  always_comb begin
    sum   = S5W'(s4_sum_q);
    sat_d = s4_sat_q;
    if (mode_q) begin
      sum   = sum + S5W'(s4_t3_q) + S5W'(s4_t4_q);
      sat_d = sat_d || s4_satx_q;
    end
    if (sum > $signed(S5W'(32767))) begin
      res_d = 16'sh7FFF;
      sat_d = 1'b1;
    end else if (sum < -$signed(S5W'(32768))) begin
      res_d = 16'sh8000;
      sat_d = 1'b1;
    end else begin
      res_d = DataW'(sum);
    end
    // Out-of-range column gives zero, no flag
    if (!s4_ok_q) begin
      res_d = '0;
      sat_d = 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ok_q   <= col_ok;
      s1_v_q    <= sample_i.value;

      s2_ok_q   <= s1_ok_q;
      s2_v_q    <= s1_v_q;
      s2_v2_q   <= p_v2.val;
      s2_t1_q   <= p_t1.val;
      s2_sat_q  <= p_v2.sat || p_t1.sat;
      s2_c0_q   <= $signed(coef[0]);
      s2_c2_q   <= $signed(coef[2]);
      s2_c3_q   <= $signed(coef[3]);
      s2_c4_q   <= $signed(coef[4]);

      s3_ok_q   <= s2_ok_q;
      s3_c0_q   <= s2_c0_q;
      s3_t1_q   <= s2_t1_q;
      s3_t2_q   <= p_t2.val;
      s3_v3_q   <= p_v3.val;
      s3_v4_q   <= p_v4.val;
      s3_c3_q   <= s2_c3_q;
      s3_c4_q   <= s2_c4_q;
      s3_sat_q  <= s2_sat_q || p_t2.sat;
      s3_satx_q <= p_v3.sat || p_v4.sat;

      s4_ok_q   <= s3_ok_q;
      s4_sum_q  <= S4W'(s3_c0_q) + S4W'(s3_t1_q) + S4W'(s3_t2_q);
      s4_t3_q   <= p_t3.val;
      s4_t4_q   <= p_t4.val;
      s4_sat_q  <= s3_sat_q;
      s4_satx_q <= s3_satx_q || p_t3.sat || p_t4.sat;

      res_q     <= res_d;
      sat_q     <= sat_d;
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.result    = res_q;
  assign result_o.saturated = sat_q;

endmodule
